// ----- rtl/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd400;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_click_event;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] double_click_window;
        logic [CFG_W-1:0] long_press_time;
    } t_cfg;

endpackage

// ----- rtl/bcc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bcc_cfg_regs
// Holds the three timing registers written through the plain write port.
// ----------------------------------------------------------------------------
module bcc_cfg_regs
    import bcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time       <= DEBOUNCE_RST;
            r_cfg.double_click_window <= WINDOW_RST;
            r_cfg.long_press_time     <= LONG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_DEBOUNCE: r_cfg.debounce_time       <= i_cfg_wdata;
                REG_WINDOW:   r_cfg.double_click_window <= i_cfg_wdata;
                REG_LONG:     r_cfg.long_press_time     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/bcc_core.sv -----
// ----------------------------------------------------------------------------
// bcc_core
// Debounce and click classification state, updated once per sample.
// ----------------------------------------------------------------------------
module bcc_core
    import bcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_level,
    input  logic [TIME_W-1:0] i_now,
    input  t_cfg              i_cfg,
    output t_click_event      o_event
);

    logic              r_stable_level, n_stable_level;
    logic              r_previous_raw, n_previous_raw;
    logic [TIME_W-1:0] r_change_time,  n_change_time;
    logic [TIME_W-1:0] r_press_time,   n_press_time;
    logic              r_long_armed,   n_long_armed;
    logic [1:0]        r_click_tally,  n_click_tally;
    logic [TIME_W-1:0] r_first_rel,    n_first_rel;

    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_first_old;
    logic [TIME_W-1:0] since_first_new;
    logic [TIME_W-1:0] since_press;
    logic              done;
    t_click_event      ev;

    always_comb begin
        n_stable_level = r_stable_level;
        n_previous_raw = i_level;
        n_change_time  = (i_level != r_previous_raw) ? i_now : r_change_time;
        n_press_time   = r_press_time;
        n_long_armed   = r_long_armed;
        n_click_tally  = r_click_tally;
        n_first_rel    = r_first_rel;
        ev             = EV_NONE;
        done           = 1'b0;

        since_change    = i_now - n_change_time;
        since_first_old = i_now - r_first_rel;

        if (since_change >= {16'd0, i_cfg.debounce_time}) begin
            if (i_level != r_stable_level) begin
                n_stable_level = i_level;
                if (!i_level) begin
                    n_press_time = i_now;
                    n_long_armed = 1'b1;
                end else begin
                    n_click_tally = r_click_tally + 2'd1;
                    if (n_click_tally == 2'd1) begin
                        n_first_rel = i_now;
                    end else if (n_click_tally == 2'd2) begin
                        if (since_first_old <= {16'd0, i_cfg.double_click_window}) begin
                            n_click_tally = 2'd0;
                            ev            = EV_DOUBLE;
                            done          = 1'b1;
                        end else begin
                            n_click_tally = 2'd1;
                            n_first_rel   = i_now;
                        end
                    end
                end
            end
        end else begin
            done = 1'b1;
        end

        since_press     = i_now - n_press_time;
        since_first_new = i_now - n_first_rel;

        if (!done) begin
            if (!n_stable_level && n_long_armed &&
                since_press >= {16'd0, i_cfg.long_press_time}) begin
                n_long_armed  = 1'b0;
                n_click_tally = 2'd0;
                ev            = EV_LONG;
            end else if (n_click_tally == 2'd1 &&
                         since_first_new > {16'd0, i_cfg.double_click_window}) begin
                n_click_tally = 2'd0;
                ev            = EV_SINGLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_level <= 1'b1;
            r_previous_raw <= 1'b1;
            r_change_time  <= '0;
            r_press_time   <= '0;
            r_long_armed   <= 1'b0;
            r_click_tally  <= 2'd0;
            r_first_rel    <= '0;
        end else if (i_valid) begin
            r_stable_level <= n_stable_level;
            r_previous_raw <= n_previous_raw;
            r_change_time  <= n_change_time;
            r_press_time   <= n_press_time;
            r_long_armed   <= n_long_armed;
            r_click_tally  <= n_click_tally;
            r_first_rel    <= n_first_rel;
        end
    end

    assign o_event = ev;

`ifndef NO_ASSERTIONS
    // A pending tally never rests above one click.
    a_tally_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_click_tally == 2'd0 || r_click_tally == 2'd1)
        else $error("click tally left above one");

    // A reported long press disarms the timer.
    a_long_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_event == EV_LONG |=> !r_long_armed && r_click_tally == 2'd0)
        else $error("long press did not disarm");

    // Any click event clears the pending tally.
    a_click_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (o_event == EV_SINGLE || o_event == EV_DOUBLE) |=>
        r_click_tally == 2'd0)
        else $error("click event left tally pending");

    // Without a sample the debounced level and the click tally hold.
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |=> $stable(r_stable_level) && $stable(r_click_tally))
        else $error("state changed without a sample");
`endif

endmodule

// ----- rtl/button_click_classifier_top.sv -----
// ----------------------------------------------------------------------------
// button_click_classifier_top
// Debounces an active-low button and reports single, double and long presses.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the slave stream carries one sample of the button pin
// (tdata bit 0, 0 means pressed) and a free-running millisecond timestamp
// (tdata bits 32:1). Every sample produces exactly one transaction on the
// master stream whose tdata bits 1:0 hold the event: none, single click,
// double click or long press.
// A sample accepted on the slave side sits in the input register and is then
// passed through the classifier into the output register, where the result
// shows on the master side. Throughput is one sample per cycle while the
// receiver does not stall; the classifier state is updated as a sample moves
// between the two registers.
// When the receiver stalls, the output register holds its result and the
// input register can still take one more sample; further samples wait with
// s_axis_tready low until the output is taken.
// Reset (i_rst_n low, synchronous) empties both registers, sets the button
// to released with no pending clicks and loads the timing registers with
// 50 ms debounce, 400 ms double-click window and 1000 ms long press.
// The timing registers are written through i_cfg_we/i_cfg_addr/i_cfg_wdata
// and should only be changed while no sample is in flight.
// ----------------------------------------------------------------------------
module button_click_classifier_top
    import bcc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    // Sample stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [0] raw_level, [32:1] now_ms, rest zero
    // Event stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [1:0] click_event, rest zero
);

    t_cfg              cfg;
    logic              r_in_valid;
    logic              r_in_level;
    logic [TIME_W-1:0] r_in_now;
    logic              r_out_valid;
    t_click_event      r_out_event;
    t_click_event      core_event;
    logic              advance;
    logic              process;

    bcc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // The second stage moves whenever the output register is free or drained.
    assign advance       = !r_out_valid || m_axis_tready;
    assign process       = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_level <= s_axis_tdata[0];
            r_in_now   <= s_axis_tdata[TIME_W:1];
        end
    end

    bcc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (process),
        .i_level (r_in_level),
        .i_now   (r_in_now),
        .i_cfg   (cfg),
        .o_event (core_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_event <= core_event;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-2){1'b0}}, r_out_event};

endmodule
